FILE: sv/s2l_pkg.sv
// ----------------------------------------------------------------------------
// s2l_pkg: shared constants and tables for the sRGB to CIELAB converter
// Holds the gamma linearization table, the RGB to XYZ matrix, the white
// point divisors and the stage counts of the arithmetic pipelines.
// ----------------------------------------------------------------------------
package s2l_pkg;

	localparam int QBITS = 30;
	localparam logic [63:0] QONE = 64'd1 << QBITS;
	localparam logic [63:0] QHALF = 64'd1 << (QBITS - 1);

	// Unsigned Q30 values that never exceed 2^31 - 1.
	localparam int QW = 31;
	typedef logic [QW-1:0] q30_t;
	typedef q30_t lin_tab_t [256];

	// Width of the scaled XYZ numerators and of the linear-segment quotient.
	localparam int NUM_W = 48;
	localparam int LSEG_NUM_W = 37;
	localparam int LSEG_Q_W = 27;

	// A division by a constant takes three stages.
	localparam int DIV_LAT = 3;
	// The cube root resolves one bit in two stages.
	localparam int CBRT_LAT = 2 * QW;
	// The linear segment registers its numerator once before its division.
	localparam int LSEG_PAD = CBRT_LAT - DIV_LAT - 1;

	localparam int unsigned MAT [3][3] = '{
		'{4124, 3576, 1805},
		'{2126, 7152, 722},
		'{193, 1192, 9505}
	};
	localparam int unsigned SCALE [3] = '{10, 1, 10};
	localparam int unsigned DEN [3] = '{95047, 10000, 108883};
	localparam int unsigned HALF [3] = '{47523, 5000, 54441};

	// 16/116 in Q30, rounded.
	localparam logic [63:0] C16 = ((64'd16 << QBITS) + 64'd58) / 64'd116;
	localparam logic [QW-1:0] C16_Q = C16[QW-1:0];
	// Threshold of the linear segment: t * 10^6 > 8856 * 2^30.
	localparam logic [63:0] KNEE = 64'd8856 << QBITS;

	function automatic logic [63:0] fifth_root(logic [63:0] s);
		logic [63:0] y;
		logic [63:0] c;
		logic [63:0] p;
		y = '0;
		for (int b = QBITS; b >= 0; b--) begin
			c = y | (64'd1 << b);
			if (c <= QONE) begin
				p = (c * c) >> QBITS;
				p = (p * p) >> QBITS;
				p = (p * c) >> QBITS;
				if (p <= s) begin
					y = c;
				end
			end
		end
		return y;
	endfunction

	function automatic logic [63:0] linearize(logic [63:0] code);
		logic [63:0] v;
		logic [63:0] s;
		logic [63:0] r;
		if (code * 64'd100000 <= 64'd1031475) begin
			r = (((code << QBITS) * 64'd100) + 64'd164730) / 64'd329460;
		end else begin
			v = (((code * 64'd1000 + 64'd14025) << QBITS) + 64'd134512) / 64'd269025;
			if (v > QONE) begin
				v = QONE;
			end
			s = (v * v + QHALF) >> QBITS;
			r = (s * fifth_root(s) + QHALF) >> QBITS;
		end
		return r;
	endfunction

	function automatic lin_tab_t build_lin_table();
		lin_tab_t t;
		logic [63:0] e;
		for (int i = 0; i < 256; i++) begin
			e = linearize(64'(i));
			t[i] = e[QW-1:0];
		end
		return t;
	endfunction

	localparam lin_tab_t LIN_TABLE = build_lin_table();

	// Rounds n / 2^30 to nearest, half away from zero.
	function automatic logic signed [22:0] round_q(logic signed [51:0] n);
		logic [51:0] m;
		logic [51:0] q;
		m = n[51] ? 52'(-n) : 52'(n);
		q = (m + 52'(QHALF)) >> QBITS;
		return n[51] ? -$signed(q[22:0]) : $signed(q[22:0]);
	endfunction

endpackage

FILE: sv/s2l_div.sv
// ----------------------------------------------------------------------------
// s2l_div: pipelined division by a constant
// Multiplies by a rounded-up reciprocal in three register stages.
// ----------------------------------------------------------------------------
module s2l_div #(
	parameter int NW = 48,
	parameter int QN = 31,
	parameter int DIVISOR = 10000
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	output logic [QN-1:0] quo
);
	// With S = NW + clog2(DIVISOR) and M = ceil(2^S / DIVISOR), the excess of
	// M * DIVISOR over 2^S stays below 2^(S-NW), so (num * M) >> S is the
	// exact quotient for every numerator below 2^NW.
	localparam int DW = $clog2(DIVISOR);
	localparam int S = NW + DW;
	localparam int MW = NW + 1;
	localparam int PW = NW + MW;
	localparam int NL = NW / 2;
	localparam int NH = NW - NL;
	localparam int ML = MW / 2;
	localparam int MH = MW - ML;
	localparam logic [127:0] M_FULL =
		((128'd1 << S) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
	localparam logic [MW-1:0] M = M_FULL[MW-1:0];
	localparam logic [ML-1:0] M_LO = M[ML-1:0];
	localparam logic [MH-1:0] M_HI = M[MW-1:ML];

	logic [NL+ML-1:0] pp_ll_s1;
	logic [NL+MH-1:0] pp_lh_s1;
	logic [NH+ML-1:0] pp_hl_s1;
	logic [NH+MH-1:0] pp_hh_s1;
	logic [PW-1:0]    ends_s2;
	logic [PW-1:0]    mid_s2;
	logic [PW-1:0]    prod;
	logic [QN-1:0]    quo_s3;

	// Four partial products of half width.
	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= (NL+ML)'(num[NL-1:0]) * (NL+ML)'(M_LO);
			pp_lh_s1 <= (NL+MH)'(num[NL-1:0]) * (NL+MH)'(M_HI);
			pp_hl_s1 <= (NH+ML)'(num[NW-1:NL]) * (NH+ML)'(M_LO);
			pp_hh_s1 <= (NH+MH)'(num[NW-1:NL]) * (NH+MH)'(M_HI);
		end
	end

	// The outer products do not overlap, so they only need concatenation.
	always_ff @(posedge clk) begin
		if (en) begin
			ends_s2 <= {pp_hh_s1, pp_ll_s1};
			mid_s2 <= (PW'(pp_lh_s1) << ML) + (PW'(pp_hl_s1) << NL);
		end
	end

	assign prod = ends_s2 + mid_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3 <= prod[S +: QN];
		end
	end

	assign quo = quo_s3;
endmodule

FILE: sv/s2l_cbrt.sv
// ----------------------------------------------------------------------------
// s2l_cbrt: pipelined Q30 cube root
// Finds the largest y with truncated y^3 <= t, one bit per two stages.
// ----------------------------------------------------------------------------
module s2l_cbrt (
	input  logic           clk,
	input  logic           en,
	input  s2l_pkg::q30_t  t,
	output s2l_pkg::q30_t  y
);
	import s2l_pkg::*;

	q30_t t_s [0:QW-1];
	q30_t y_s [0:QW];
	q30_t t_m [0:QW-1];
	q30_t y_m [0:QW-1];
	logic [31:0] p_m [0:QW-1];

	assign t_s[0] = t;
	assign y_s[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int B = QW - 1 - k;
		q30_t c_a;
		q30_t c_b;
		logic [63:0] sq;
		logic [63:0] cu;
		logic keep;

		// First half: square of the candidate.
		assign c_a = y_s[k] | (QW'(1) << B);
		assign sq = 64'(c_a) * 64'(c_a);
		always_ff @(posedge clk) begin
			if (en) begin
				t_m[k] <= t_s[k];
				y_m[k] <= y_s[k];
				p_m[k] <= sq[61:30];
			end
		end

		// Second half: cube and trial compare.
		assign c_b = y_m[k] | (QW'(1) << B);
		assign cu = 64'(p_m[k]) * 64'(c_b);
		assign keep = (cu >> QBITS) <= 64'(t_m[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				y_s[k+1] <= keep ? c_b : y_m[k];
			end
		end
		if (k < QW - 1) begin : g_t
			always_ff @(posedge clk) begin
				if (en) begin
					t_s[k+1] <= t_m[k];
				end
			end
		end
	end

	assign y = y_s[QW];
endmodule

FILE: sv/srgb_to_cielab.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab: 8-bit sRGB to CIELAB (D65) converter
// Fully pipelined; L*, a* and b* come out in units of 1/256.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and delivers one result per pixel, in
// order. A result passes through every stage below and is held in the output
// register until it is transferred out. The latency is set mostly by the
// cube root, which resolves one bit per two stages (62 stages). Table lookup,
// matrix products and the scaled sums take three stages, the white point
// division by reciprocal multiplication takes three, and the Lab products
// and the output register take two. All stages advance together; when the
// output register holds a result that has not been taken, the whole
// pipeline holds, and in_ready drops in the same cycle, so nothing is lost
// or repeated. While the output side takes results, a new pixel can be
// transferred in every cycle.
module srgb_to_cielab (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        lightness,
	output logic signed [15:0] a_star,
	output logic signed [15:0] b_star
);
	import s2l_pkg::*;

	// Lookup, products, sums, division, cube root, Lab products, rounding.
	localparam int LAT = 3 + DIV_LAT + CBRT_LAT + 2;

	logic adv;
	logic [LAT:1] valid_q;

	// The pipeline moves whenever the output register is empty or being read.
	assign adv = !valid_q[LAT] || out_ready;
	assign in_ready = adv;
	assign out_valid = valid_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[LAT-1:1], in_valid};
		end
	end

	// Gamma linearization by table lookup.
	q30_t lin_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s1[0] <= LIN_TABLE[red];
			lin_s1[1] <= LIN_TABLE[green];
			lin_s1[2] <= LIN_TABLE[blue];
		end
	end

	// Per XYZ component: matrix row, white point division, f(t).
	q30_t f_c [3];

	for (genvar j = 0; j < 3; j++) begin : g_comp
		logic [44:0] prod_s2 [3];
		logic [NUM_W-1:0] sum;
		logic [NUM_W-1:0] num_s3;
		q30_t t_d;
		q30_t cb;
		logic [LSEG_NUM_W-1:0] lnum;
		logic [LSEG_NUM_W-1:0] lnum_s7;
		logic [LSEG_Q_W-1:0] lq;
		logic [LSEG_Q_W-1:0] lpad [0:LSEG_PAD];
		logic sel_pad [0:CBRT_LAT];
		logic [50:0] knee_prod;

		for (genvar i = 0; i < 3; i++) begin : g_mul
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s2[i] <= 45'(lin_s1[i]) * 45'(MAT[j][i]);
				end
			end
		end

		assign sum = NUM_W'(prod_s2[0]) + NUM_W'(prod_s2[1]) + NUM_W'(prod_s2[2]);
		always_ff @(posedge clk) begin
			if (adv) begin
				num_s3 <= sum * NUM_W'(SCALE[j]) + NUM_W'(HALF[j]);
			end
		end

		// Rounded ratio to the white point, Q30.
		s2l_div #(.NW(NUM_W), .QN(QW), .DIVISOR(int'(DEN[j]))) u_div (
			.clk(clk), .en(adv), .num(num_s3), .quo(t_d)
		);

		s2l_cbrt u_cbrt (.clk(clk), .en(adv), .t(t_d), .y(cb));

		// Linear segment 7.787 * t; only exact where it is selected, which
		// needs t below 2^24.
		assign lnum = LSEG_NUM_W'(t_d[23:0]) * LSEG_NUM_W'(7787) + LSEG_NUM_W'(500);
		always_ff @(posedge clk) begin
			if (adv) begin
				lnum_s7 <= lnum;
			end
		end
		s2l_div #(.NW(LSEG_NUM_W), .QN(LSEG_Q_W), .DIVISOR(1000)) u_lseg (
			.clk(clk), .en(adv), .num(lnum_s7), .quo(lq)
		);

		assign knee_prod = 51'(t_d) * 51'd1000000;
		assign lpad[0] = lq;
		assign sel_pad[0] = 64'(knee_prod) > KNEE;

		for (genvar d = 0; d < LSEG_PAD; d++) begin : g_lpad
			always_ff @(posedge clk) begin
				if (adv) begin
					lpad[d+1] <= lpad[d];
				end
			end
		end
		for (genvar d = 0; d < CBRT_LAT; d++) begin : g_spad
			always_ff @(posedge clk) begin
				if (adv) begin
					sel_pad[d+1] <= sel_pad[d];
				end
			end
		end

		assign f_c[j] = sel_pad[CBRT_LAT] ? cb : QW'(lpad[LSEG_PAD]) + C16_Q;
	end

	// Lab products in Q30, scaled by 256.
	localparam logic signed [51:0] L_OFF = 52'sd4398046511104;
	logic signed [51:0] fx;
	logic signed [51:0] fy;
	logic signed [51:0] fz;
	logic signed [51:0] l_s69;
	logic signed [51:0] a_s69;
	logic signed [51:0] b_s69;

	assign fx = $signed(52'(f_c[0]));
	assign fy = $signed(52'(f_c[1]));
	assign fz = $signed(52'(f_c[2]));

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s69 <= fy * 52'sd29696 - L_OFF;
			a_s69 <= (fx - fy) * 52'sd128000;
			b_s69 <= (fy - fz) * 52'sd51200;
		end
	end

	// Rounding and saturation into the output register.
	logic signed [22:0] l_r;
	logic signed [22:0] a_r;
	logic signed [22:0] b_r;

	assign l_r = round_q(l_s69);
	assign a_r = round_q(a_s69);
	assign b_r = round_q(b_s69);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (l_r < 0) begin
				lightness <= '0;
			end else if (l_r > 23'sd25600) begin
				lightness <= 15'd25600;
			end else begin
				lightness <= l_r[14:0];
			end
			if (a_r > 23'sd32767) begin
				a_star <= 16'sh7fff;
			end else if (a_r < -23'sd32768) begin
				a_star <= 16'sh8000;
			end else begin
				a_star <= a_r[15:0];
			end
			if (b_r > 23'sd32767) begin
				b_star <= 16'sh7fff;
			end else if (b_r < -23'sd32768) begin
				b_star <= 16'sh8000;
			end else begin
				b_star <= b_r[15:0];
			end
		end
	end

	// An accepted pixel always enters the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_q[1])
		else $error("accepted pixel did not enter the pipeline");

	// While stalled, the occupancy of the pipeline does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_q))
		else $error("pipeline moved during a stall");

	// Lightness never leaves its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lightness <= 15'd25600)
		else $error("lightness out of range");
endmodule
